// File: hw/rtl/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types and constants of the PSNR / RMSE image quality meter.
// ----------------------------------------------------------------------------
package prm_pkg;

    localparam int unsigned MAX_SAMPLES_DEF      = 16777216;
    localparam int unsigned SAMPLE_FRAC_BITS_DEF = 6;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PEAK_W   = 10;
    localparam int unsigned RMSE_W   = 16;
    localparam int unsigned PSNR_W   = 16;
    localparam int unsigned LOG_FRAC = 16;
    localparam int unsigned MUL_W    = 32;

    localparam logic [PEAK_W-1:0] PEAK_RESET      = 10'd255;
    localparam logic [17:0]       TEN_LOG10_2_Q16 = 18'd197283;
    localparam logic [RMSE_W-1:0] RMSE_MAX        = 16'hFFFF;
    localparam logic [PSNR_W-1:0] PSNR_MAX        = 16'h7FFF;
    localparam logic [PSNR_W-1:0] PSNR_MIN        = 16'h8000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SQRT,
        S_PK2,
        S_NUM,
        S_LOAD,
        S_NORM,
        S_SQR_MUL,
        S_SQR_UPD,
        S_SCALE_MUL,
        S_SCALE,
        S_DONE
    } prm_state_t;

    typedef struct packed {
        logic [RMSE_W-1:0] rmse_value;
        logic [PSNR_W-1:0] psnr_db;
        logic              psnr_infinite;
        logic              count_saturated;
    } prm_result_t;

endpackage

// File: hw/rtl/prm_if.sv
// ----------------------------------------------------------------------------
// prm_in_if / prm_out_if
// Valid/ready channels carrying sample pairs in and quality results out.
// ----------------------------------------------------------------------------
interface prm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [prm_pkg::SAMPLE_W-1:0] sample_ref;
    logic signed [prm_pkg::SAMPLE_W-1:0] sample_test;
    logic                                last_sample;

    modport source (output valid, output sample_ref, output sample_test,
                    output last_sample, input ready);
    modport sink   (input valid, input sample_ref, input sample_test,
                    input last_sample, output ready);
endinterface

interface prm_out_if;
    logic                              valid;
    logic                              ready;
    logic [prm_pkg::RMSE_W-1:0]        rmse_value;
    logic signed [prm_pkg::PSNR_W-1:0] psnr_db;
    logic                              psnr_infinite;
    logic                              count_saturated;

    modport source (output valid, output rmse_value, output psnr_db,
                    output psnr_infinite, output count_saturated, input ready);
    modport sink   (input valid, input rmse_value, input psnr_db,
                    input psnr_infinite, input count_saturated, output ready);
endinterface

// File: hw/rtl/prm_accum.sv
// ----------------------------------------------------------------------------
// prm_accum
// Three-stage squared-difference accumulator with saturating sample count.
// ----------------------------------------------------------------------------
module prm_accum #(
    parameter int unsigned MAX_SAMPLES = prm_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned CNT_W       = 25,
    parameter int unsigned SUM_W       = 57
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic signed [prm_pkg::SAMPLE_W-1:0] sample_ref,
    input  logic signed [prm_pkg::SAMPLE_W-1:0] sample_test,
    input  logic                                last_sample,
    output logic                                done,
    output logic [SUM_W-1:0]                    sum_total,
    output logic [CNT_W-1:0]                    count_total
);

    localparam int unsigned SW = prm_pkg::SAMPLE_W;

    logic              v1_reg, v1_next, l1_reg, l1_next;
    logic [SW-1:0]     ad_reg, ad_next;
    logic              v2_reg, v2_next, l2_reg, l2_next;
    logic [2*SW-1:0]   sq_reg, sq_next;
    logic [SUM_W-1:0]  sum_reg, sum_next, tot_sum_reg, tot_sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, tot_cnt_reg, tot_cnt_next;
    logic              done_reg, done_next;

    logic signed [SW:0] diff;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_add;

    always_comb
    begin
        diff    = (SW+1)'(sample_ref) - (SW+1)'(sample_test);
        v1_next = take;
        l1_next = last_sample;
        ad_next = diff[SW] ? SW'(-diff) : diff[SW-1:0];
        v2_next = v1_reg;
        l2_next = l1_reg;
        sq_next = ad_reg * ad_reg;

        // hold the sum once the count bound is reached
        if (cnt_reg < CNT_W'(MAX_SAMPLES))
        begin
            sum_add = sum_reg + SUM_W'(sq_reg);
            cnt_add = cnt_reg + 1'b1;
        end
        else
        begin
            sum_add = sum_reg;
            cnt_add = cnt_reg;
        end

        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        tot_sum_next = tot_sum_reg;
        tot_cnt_next = tot_cnt_reg;
        done_next    = 1'b0;
        if (v2_reg)
        begin
            if (l2_reg)
            begin
                tot_sum_next = sum_add;
                tot_cnt_next = cnt_add;
                done_next    = 1'b1;
                sum_next     = '0;
                cnt_next     = '0;
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = cnt_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            done_reg <= done_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg      <= l1_next;
        ad_reg      <= ad_next;
        l2_reg      <= l2_next;
        sq_reg      <= sq_next;
        tot_sum_reg <= tot_sum_next;
        tot_cnt_reg <= tot_cnt_next;
    end

    assign done        = done_reg;
    assign sum_total   = tot_sum_reg;
    assign count_total = tot_cnt_reg;

endmodule

// File: hw/rtl/prm_solver.sv
// ----------------------------------------------------------------------------
// prm_solver
// Sequencer for mean, square root and log-domain PSNR around one shared
// 32x32 multiplier and a subtract/compare step.
// ----------------------------------------------------------------------------
module prm_solver #(
    parameter int unsigned MAX_SAMPLES      = prm_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned SAMPLE_FRAC_BITS = prm_pkg::SAMPLE_FRAC_BITS_DEF,
    parameter int unsigned CNT_W            = 25,
    parameter int unsigned SUM_W            = 57
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_W-1:0]           sum_in,
    input  logic [CNT_W-1:0]           count_in,
    input  logic [prm_pkg::PEAK_W-1:0] peak,
    input  logic                       out_free,
    output logic                       res_valid,
    output prm_pkg::prm_result_t       res
);

    localparam int unsigned PW     = prm_pkg::PEAK_W;
    localparam int unsigned MW     = prm_pkg::MUL_W;
    localparam int unsigned LF     = prm_pkg::LOG_FRAC;
    localparam int unsigned SH2    = 2 * SAMPLE_FRAC_BITS;
    localparam int unsigned NUM_W  = 2 * PW + CNT_W + SH2;
    localparam int unsigned LOG_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int unsigned P_W    = $clog2(LOG_W);
    localparam int unsigned LV_W   = P_W + LF;
    localparam int unsigned ROOT_W = (SUM_W + 1) / 2;
    localparam int unsigned CTR_W  = $clog2(LOG_W + 1);

    prm_pkg::prm_state_t state_reg, state_next;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   dq_reg, dq_next;
    logic [SUM_W-1:0]   root_reg, root_next;
    logic [SUM_W-1:0]   bit_reg, bit_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    logic [2*MW-1:0]    prod_reg, prod_next;
    logic [LOG_W-1:0]   lx_reg, lx_next;
    logic [P_W-1:0]     lp_reg, lp_next;
    logic [MW-1:0]      y_reg, y_next;
    logic [LF-1:0]      frac_reg, frac_next;
    logic               sel_reg, sel_next;
    logic [LV_W-1:0]    lnum_reg, lnum_next, lsum_reg, lsum_next;
    logic               neg_reg, neg_next;
    logic [prm_pkg::RMSE_W-1:0] rmse_reg, rmse_next;
    logic [prm_pkg::PSNR_W-1:0] psnr_reg, psnr_next;
    logic               inf_reg, inf_next, csat_reg, csat_next;

    logic [MW-1:0]      mul_a, mul_b;
    logic [2*MW-1:0]    mul_p;
    logic [CNT_W:0]     trial;
    logic               ge;
    logic [SUM_W:0]     rb;
    logic               take_root;
    logic [SUM_W-1:0]   root_step;
    logic [MW:0]        sq_top;
    logic [LF-1:0]      frac_step;
    logic signed [LV_W:0] ldiff;
    logic [LV_W:0]      lmag;
    logic [2*MW-1:0]    rnd;
    logic [2*MW-25:0]   scaled;
    logic               sum_zero;

    assign mul_p = mul_a * mul_b;

    // shared arithmetic
    always_comb
    begin
        trial     = {rem_reg, dq_reg[SUM_W-1]};
        ge        = trial >= {1'b0, cnt_reg};
        rb        = {1'b0, root_reg} + {1'b0, bit_reg};
        take_root = {1'b0, dq_reg} >= rb;
        root_step = take_root ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
        sq_top    = prod_reg[2*MW-1:MW-1];
        frac_step = {frac_reg[LF-2:0], sq_top[MW]};
        ldiff     = $signed({1'b0, lnum_reg}) - $signed({1'b0, lsum_reg});
        lmag      = ldiff[LV_W] ? (LV_W+1)'(-ldiff) : ldiff[LV_W:0];
        rnd       = prod_reg + (2*MW)'(1 << 23);
        scaled    = rnd[2*MW-1:24];
        sum_zero  = (sum_in == '0) || (count_in == '0);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            prm_pkg::S_PK2:
            begin
                mul_a = MW'(peak);
                mul_b = MW'(peak);
            end
            prm_pkg::S_NUM:
            begin
                mul_a = MW'(prod_reg[2*PW-1:0]);
                mul_b = MW'(cnt_reg);
            end
            prm_pkg::S_SQR_MUL:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            prm_pkg::S_SCALE_MUL:
            begin
                mul_a = MW'(lmag);
                mul_b = MW'(prm_pkg::TEN_LOG10_2_Q16);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prm_pkg::S_IDLE:
                if (start)
                    state_next = sum_zero ? prm_pkg::S_DONE : prm_pkg::S_DIV;
            prm_pkg::S_DIV:
                if (ctr_reg == CTR_W'(SUM_W - 1))
                    state_next = prm_pkg::S_SQRT;
            prm_pkg::S_SQRT:
                if (bit_reg[SUM_W-1:2] == '0)
                    state_next = prm_pkg::S_PK2;
            prm_pkg::S_PK2:
                state_next = prm_pkg::S_NUM;
            prm_pkg::S_NUM:
                state_next = prm_pkg::S_LOAD;
            prm_pkg::S_LOAD:
                state_next = (prod_reg == '0) ? prm_pkg::S_DONE : prm_pkg::S_NORM;
            prm_pkg::S_NORM:
                if (lx_reg[LOG_W-1])
                    state_next = prm_pkg::S_SQR_MUL;
            prm_pkg::S_SQR_MUL:
                state_next = prm_pkg::S_SQR_UPD;
            prm_pkg::S_SQR_UPD:
                if (ctr_reg == CTR_W'(LF - 1))
                    state_next = sel_reg ? prm_pkg::S_SCALE_MUL : prm_pkg::S_NORM;
                else
                    state_next = prm_pkg::S_SQR_MUL;
            prm_pkg::S_SCALE_MUL:
                state_next = prm_pkg::S_SCALE;
            prm_pkg::S_SCALE:
                state_next = prm_pkg::S_DONE;
            prm_pkg::S_DONE:
                if (out_free)
                    state_next = prm_pkg::S_IDLE;
            default:
                state_next = prm_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        ctr_next  = ctr_reg;
        prod_next = prod_reg;
        lx_next   = lx_reg;
        lp_next   = lp_reg;
        y_next    = y_reg;
        frac_next = frac_reg;
        sel_next  = sel_reg;
        lnum_next = lnum_reg;
        lsum_next = lsum_reg;
        neg_next  = neg_reg;
        rmse_next = rmse_reg;
        psnr_next = psnr_reg;
        inf_next  = inf_reg;
        csat_next = csat_reg;
        case (state_reg)
            prm_pkg::S_IDLE:
                if (start)
                begin
                    sum_next  = sum_in;
                    cnt_next  = count_in;
                    dq_next   = sum_in;
                    rem_next  = '0;
                    ctr_next  = '0;
                    inf_next  = sum_zero;
                    csat_next = (count_in == CNT_W'(MAX_SAMPLES));
                    rmse_next = '0;
                    psnr_next = prm_pkg::PSNR_MAX;
                end
            prm_pkg::S_DIV:
            begin
                rem_next = ge ? CNT_W'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], ge};
                ctr_next = ctr_reg + 1'b1;
                root_next = '0;
                bit_next  = SUM_W'(1) << (2 * (ROOT_W - 1));
            end
            prm_pkg::S_SQRT:
            begin
                if (take_root)
                    dq_next = dq_reg - rb[SUM_W-1:0];
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                rmse_next = (root_step[SUM_W-1:prm_pkg::RMSE_W] != '0) ?
                            prm_pkg::RMSE_MAX : root_step[prm_pkg::RMSE_W-1:0];
            end
            prm_pkg::S_PK2, prm_pkg::S_NUM, prm_pkg::S_SQR_MUL:
                prod_next = mul_p;
            prm_pkg::S_LOAD:
            begin
                // zero peak register gives the lowest PSNR
                psnr_next = prm_pkg::PSNR_MIN;
                lx_next   = LOG_W'(prod_reg[NUM_W-SH2-1:0]) << SH2;
                lp_next   = P_W'(LOG_W - 1);
                sel_next  = 1'b0;
            end
            prm_pkg::S_NORM:
            begin
                ctr_next  = '0;
                frac_next = '0;
                y_next    = lx_reg[LOG_W-1 -: MW];
                if (!lx_reg[LOG_W-1])
                begin
                    lx_next = lx_reg << 1;
                    lp_next = lp_reg - 1'b1;
                end
            end
            prm_pkg::S_SQR_UPD:
            begin
                y_next    = sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
                frac_next = frac_step;
                ctr_next  = ctr_reg + 1'b1;
                if (ctr_reg == CTR_W'(LF - 1))
                begin
                    if (sel_reg)
                        lsum_next = {lp_reg, frac_step};
                    else
                    begin
                        lnum_next = {lp_reg, frac_step};
                        lx_next   = LOG_W'(sum_reg);
                        lp_next   = P_W'(LOG_W - 1);
                        sel_next  = 1'b1;
                    end
                end
            end
            prm_pkg::S_SCALE_MUL:
            begin
                prod_next = mul_p;
                neg_next  = ldiff[LV_W];
            end
            prm_pkg::S_SCALE:
            begin
                if (neg_reg)
                    psnr_next = (scaled > (2*MW-24)'(32768)) ? prm_pkg::PSNR_MIN :
                                prm_pkg::PSNR_W'(~scaled[prm_pkg::PSNR_W-1:0] + 1'b1);
                else
                    psnr_next = (scaled > (2*MW-24)'(32767)) ? prm_pkg::PSNR_MAX :
                                scaled[prm_pkg::PSNR_W-1:0];
            end
            default:
            begin
                ctr_next = ctr_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        res_valid           = (state_reg == prm_pkg::S_DONE) && out_free;
        res.rmse_value      = rmse_reg;
        res.psnr_db         = psnr_reg;
        res.psnr_infinite   = inf_reg;
        res.count_saturated = csat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= prm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        ctr_reg  <= ctr_next;
        prod_reg <= prod_next;
        lx_reg   <= lx_next;
        lp_reg   <= lp_next;
        y_reg    <= y_next;
        frac_reg <= frac_next;
        sel_reg  <= sel_next;
        lnum_reg <= lnum_next;
        lsum_reg <= lsum_next;
        neg_reg  <= neg_next;
        rmse_reg <= rmse_next;
        psnr_reg <= psnr_next;
        inf_reg  <= inf_next;
        csat_reg <= csat_next;
    end

endmodule

// File: hw/rtl/psnr_rmse_meter_core.sv
// ----------------------------------------------------------------------------
// psnr_rmse_meter_core
// PSNR and RMSE meter over a stream of reference / test sample pairs.
// ----------------------------------------------------------------------------
// Accumulation takes one sample pair per cycle through a three-stage pipeline.
// After the last pair, ready stays low while the solver sequences the divide,
// the square root and two logs, until the result is loaded; a result stall
// lengthens this. Zero error skips all steps, a zero peak skips the logs.
// Reset (rst_n, async low) clears sums, count, handshakes; peak returns to 255.
module psnr_rmse_meter_core #(
    parameter int unsigned MAX_SAMPLES      = prm_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned SAMPLE_FRAC_BITS = prm_pkg::SAMPLE_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    prm_in_if.sink                     samples,
    prm_out_if.source                  result,
    input  logic                       cfg_wr_en,
    input  logic [prm_pkg::PEAK_W-1:0] cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W = 2 * prm_pkg::SAMPLE_W + CNT_W;

    logic [prm_pkg::PEAK_W-1:0] peak_reg, peak_next;
    logic                       busy_reg, busy_next;
    logic                       out_valid_reg, out_valid_next;
    prm_pkg::prm_result_t       out_reg, out_next;

    logic                 accept;
    logic                 acc_done;
    logic [SUM_W-1:0]     acc_sum;
    logic [CNT_W-1:0]     acc_cnt;
    logic                 out_free;
    logic                 res_load;
    prm_pkg::prm_result_t res;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || result.ready;

    prm_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (accept),
        .sample_ref  (samples.sample_ref),
        .sample_test (samples.sample_test),
        .last_sample (samples.last_sample),
        .done        (acc_done),
        .sum_total   (acc_sum),
        .count_total (acc_cnt)
    );

    prm_solver #(
        .MAX_SAMPLES      (MAX_SAMPLES),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
        .CNT_W            (CNT_W),
        .SUM_W            (SUM_W)
    ) u_solver (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (acc_done),
        .sum_in    (acc_sum),
        .count_in  (acc_cnt),
        .peak      (peak_reg),
        .out_free  (out_free),
        .res_valid (res_load),
        .res       (res)
    );

    always_comb
    begin
        peak_next = cfg_wr_en ? cfg_wr_data : peak_reg;

        // block new transactions from the last pair until its result is loaded
        busy_next = busy_reg;
        if (accept && samples.last_sample)
            busy_next = 1'b1;
        else if (res_load)
            busy_next = 1'b0;

        out_next       = res_load ? res : out_reg;
        out_valid_next = res_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= prm_pkg::PEAK_RESET;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            peak_reg      <= peak_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign samples.ready          = !busy_reg;
    assign result.valid           = out_valid_reg;
    assign result.rmse_value      = out_reg.rmse_value;
    assign result.psnr_db         = out_reg.psnr_db;
    assign result.psnr_infinite   = out_reg.psnr_infinite;
    assign result.count_saturated = out_reg.count_saturated;

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.last_sample) |=> !samples.ready)
        else $error("ready still high after last sample transaction");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || result.ready))
        else $error("result loaded over a pending transaction");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> busy_reg)
        else $error("result produced without a pending last sample");

    a_inf_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.psnr_infinite) |->
            (result.rmse_value == '0 && result.psnr_db == prm_pkg::PSNR_MAX))
        else $error("infinite PSNR with nonzero error fields");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PSNR / RMSE meter: directed table, then random
// images under varying source/sink idling, each result checked against a
// fixed-point predictor of the accumulator and solver.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0]   sref;
        logic signed [15:0]   stest;
        logic                 last;
        logic                 known;
        prm_pkg::prm_result_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [prm_pkg::PEAK_W-1:0] cfg_wr_data = '0;

    prm_in_if  samples();
    prm_out_if result();

    psnr_rmse_meter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples.sink),
        .result      (result.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [63:0] err_sum;
    logic [24:0] pair_count;
    logic [9:0]  peak;
    prm_pkg::prm_result_t quality_q[$];

    int  fail_cnt = 0;
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_sink = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_cycles = 0;
    longint cycle_cnt = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_q16(logic [63:0] x);
        int p;
        logic [63:0] y;
        logic [63:0] frac;
        p = 63;
        frac = 0;
        while (p > 0 && x[p] == 1'b0)
            p--;
        y = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32))
            begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'((64'(p) << 16) | frac);
    endfunction

    // accumulate one pair; returns 1 and the quality result on the last pair
    function automatic bit predict_quality(logic signed [15:0] a, logic signed [15:0] b,
                                           logic last, output prm_pkg::prm_result_t r);
        longint d;
        logic [63:0] sq;
        logic [63:0] num;
        logic [63:0] rm;
        logic [63:0] mag;
        longint l;
        logic signed [15:0] ps;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        sq = 64'(d) * 64'(d);
        if (pair_count < 25'(prm_pkg::MAX_SAMPLES_DEF))
        begin
            err_sum = (err_sum > ~64'd0 - sq) ? ~64'd0 : err_sum + sq;
            pair_count++;
        end
        r = '0;
        if (!last)
            return 1'b0;
        if (pair_count == 0 || err_sum == 0)
        begin
            r.rmse_value = 16'd0;
            r.psnr_db = prm_pkg::PSNR_MAX;
            r.psnr_infinite = 1'b1;
        end
        else
        begin
            rm = int_sqrt(err_sum / 64'(pair_count));
            r.rmse_value = (rm > 64'hFFFF) ? prm_pkg::RMSE_MAX : rm[15:0];
            num = (64'(peak) * 64'(peak) * 64'(pair_count)) << 12;
            if (num == 0)
                ps = prm_pkg::PSNR_MIN;
            else
            begin
                l = log2_q16(num) - log2_q16(err_sum);
                mag = 64'(l < 0 ? -l : l) * 64'd197283;
                mag = (mag + (64'd1 << 23)) >> 24;
                if (l < 0)
                    ps = (mag > 32768) ? prm_pkg::PSNR_MIN : 16'(-longint'(mag));
                else
                    ps = (mag > 32767) ? prm_pkg::PSNR_MAX : mag[15:0];
            end
            r.psnr_db = ps;
        end
        r.count_saturated = (pair_count == 25'(prm_pkg::MAX_SAMPLES_DEF));
        err_sum = 0;
        pair_count = 0;
        return 1'b1;
    endfunction

    // source side; valid stays up after the transaction until the next call
    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        prm_pkg::prm_result_t r;
        while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid       <= 1'b1;
        samples.sample_ref  <= a;
        samples.sample_test <= b;
        samples.last_sample <= last;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        if (predict_quality(a, b, last, r))
            quality_q.push_back(r);
        @(negedge clk);
    endtask

    task automatic set_peak(logic [9:0] v);
        samples.valid <= 1'b0;
        while (quality_q.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        peak = v;
    endtask

    task automatic send_image(int n, int mode);
        logic signed [15:0] a;
        logic signed [15:0] b;
        for (int i = 0; i < n; i++)
        begin
            a = 16'($urandom);
            case (mode)
                0: b = a + 16'($urandom_range(15, 0)) - 16'sd7;
                1: b = a;
                default: b = 16'($urandom);
            endcase
            send_pair(a, b, i == n - 1);
        end
    endtask

    // sink side and checker
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_sink)
            result.ready <= 1'b0;
        else
            result.ready <= (snk_idle_pct == 0) || ($urandom_range(99, 0) >= snk_idle_pct);
    end

    // long receiver hold, counted here once requested
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_cycles <= 2000;
            hold_taken  <= 1'b1;
            hold_sink   <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_sink   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            hold_sink <= 1'b0;
    end

    always @(posedge clk)
    begin
        prm_pkg::prm_result_t e;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && result.valid && result.ready)
        begin
            if (quality_q.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_cnt++;
            end
            else
            begin
                e = quality_q.pop_front();
                if (result.rmse_value !== e.rmse_value)
                begin
                    $error("rmse_value exp %0d got %0d", e.rmse_value, result.rmse_value);
                    fail_cnt++;
                end
                if (result.psnr_db !== e.psnr_db)
                begin
                    $error("psnr_db exp %0d got %0d", $signed(e.psnr_db),
                           $signed(result.psnr_db));
                    fail_cnt++;
                end
                if (result.psnr_infinite !== e.psnr_infinite)
                begin
                    $error("psnr_infinite exp %0b got %0b", e.psnr_infinite,
                           result.psnr_infinite);
                    fail_cnt++;
                end
                if (result.count_saturated !== e.count_saturated)
                begin
                    $error("count_saturated exp %0b got %0b", e.count_saturated,
                           result.count_saturated);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_cnt > 3000000)
        begin
            $display("psnr_rmse_meter_core: mismatch");
            $finish;
        end
    end

    // directed rows: known results typed in where obvious
    stim_row_t dir_rows[] = '{
        '{16'sd0, 16'sd0, 1'b1, 1'b1, '{16'd0, prm_pkg::PSNR_MAX, 1'b1, 1'b0}},
        '{16'sd100, 16'sd100, 1'b1, 1'b1, '{16'd0, prm_pkg::PSNR_MAX, 1'b1, 1'b0}},
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, '{16'd0, prm_pkg::PSNR_MAX, 1'b1, 1'b0}},
        '{16'sh7FFF, -16'sd32768, 1'b1, 1'b1, '{16'd65535, 16'h0, 1'b0, 1'b0}},
        '{-16'sd32768, 16'sh7FFF, 1'b1, 1'b0, '0},
        '{16'sd64, 16'sd0, 1'b1, 1'b1, '{16'd64, 16'h0, 1'b0, 1'b0}},
        '{16'sd1, 16'sd0, 1'b0, 1'b0, '0},
        '{16'sd0, 16'sd1, 1'b0, 1'b0, '0},
        '{16'sd3, -16'sd5, 1'b1, 1'b0, '0},
        '{16'sh5555, 16'shAAAA, 1'b1, 1'b0, '0},
        '{16'shAAAA, 16'sh5555, 1'b1, 1'b0, '0}
    };

    initial
    begin
        prm_pkg::prm_result_t r;
        samples.valid = 1'b0;
        samples.sample_ref = '0;
        samples.sample_test = '0;
        samples.last_sample = 1'b0;
        err_sum = 0;
        pair_count = 0;
        peak = prm_pkg::PEAK_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // walk the table; typed-in rows overwrite the predicted value
        foreach (dir_rows[i])
        begin
            send_pair(dir_rows[i].sref, dir_rows[i].stest, dir_rows[i].last);
            if (dir_rows[i].known && dir_rows[i].last)
            begin
                r = quality_q.pop_back();
                if (dir_rows[i].res.psnr_infinite)
                    quality_q.push_back(dir_rows[i].res);
                else
                begin
                    r.rmse_value = dir_rows[i].res.rmse_value;
                    quality_q.push_back(r);
                end
            end
        end
        set_peak(10'd0);
        send_pair(16'sd64, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        set_peak(10'd1023);
        send_pair(16'sd1, 16'sd0, 1'b1);
        set_peak(10'd1);
        send_pair(16'sh7FFF, -16'sd32768, 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 67 : 0;
            snk_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 32 : 0;
            set_peak(ph == 2 ? prm_pkg::PEAK_RESET : 10'($urandom_range(1023, 1)));
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = 0; k < 70; k++)
            begin
                if (k % 20 == 0 && ph != 2)
                    set_peak(10'($urandom_range(1023, 0)));
                send_image($urandom_range(12, 1), $urandom_range(9, 0) < 6 ? 0 :
                           ($urandom_range(4, 0) == 0 ? 1 : 2));
            end
        end

        samples.valid <= 1'b0;
        while (quality_q.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (fail_cnt == 0)
            $display("psnr_rmse_meter_core: match");
        else
            $display("psnr_rmse_meter_core: mismatch");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/prm_pkg.sv
hw/rtl/prm_if.sv
hw/rtl/prm_accum.sv
hw/rtl/prm_solver.sv
hw/rtl/psnr_rmse_meter_core.sv
tb/sv/tb_top.sv
